[hdl/sdst_pkg.sv]
`default_nettype none

package sdst_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;

    localparam int OP_W     = 2;
    localparam int SECTOR_W = 28;
    localparam int ENTRY_W  = 12;
    localparam int WORD_W   = 32;
    localparam int ACTION_W = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int SHIFT_W  = 5;
    localparam int PAD_W    = 8;
    localparam int COUNT_W  = 13;

    localparam logic [WORD_W-1:0] UNALLOCATED = '1;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd3;

    localparam logic [ACTION_W-1:0] ACT_ZERO   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ACCESS = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SKIP   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RANGE  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LOADED = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REJECT = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_DISK_DYNAMIC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SECTORS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BITMAP_SECTORS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PADDING_SECTORS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_SECTOR      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT     = 3'd6;

    localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 5'd12;
    localparam logic [PAD_W-1:0]   BITMAP_RST      = 8'd1;

endpackage

`default_nettype wire

[hdl/sdst_in_if.sv]
`default_nettype none

interface sdst_in_if;
    logic                               valid;
    logic                               ready;
    logic [sdst_pkg::OP_W-1:0]          operation;
    logic [sdst_pkg::SECTOR_W-1:0]      sector;
    logic                               data_all_zero;
    logic [sdst_pkg::ENTRY_W-1:0]       entry_index;
    logic [sdst_pkg::WORD_W-1:0]        entry_value;
    logic                               last_of_request;

    modport source (
        output valid, operation, sector, data_all_zero, entry_index, entry_value,
               last_of_request,
        input  ready
    );

    modport sink (
        input  valid, operation, sector, data_all_zero, entry_index, entry_value,
               last_of_request,
        output ready
    );
endinterface

`default_nettype wire

[hdl/sdst_out_if.sv]
`default_nettype none

interface sdst_out_if;
    logic                               valid;
    logic                               ready;
    logic [sdst_pkg::ACTION_W-1:0]      action;
    logic [sdst_pkg::WORD_W-1:0]        file_sector;
    logic                               block_created;
    logic [sdst_pkg::WORD_W-1:0]        new_block_sector;
    logic [sdst_pkg::ENTRY_W-1:0]       table_write_index;
    logic                               end_of_request;

    modport source (
        output valid, action, file_sector, block_created, new_block_sector,
               table_write_index, end_of_request,
        input  ready
    );

    modport sink (
        input  valid, action, file_sector, block_created, new_block_sector,
               table_write_index, end_of_request,
        output ready
    );
endinterface

`default_nettype wire

[hdl/sparse_disk_sector_translate_unit.sv]
`default_nettype none

// Sparse virtual-disk sector translator. Each input transfer is one sector access
// (read, write, format) or one load of a block allocation table entry, and yields
// exactly one result transfer. The table lives in a single-port-read, single-port-
// write synchronous memory of TABLE_DEPTH words; each item goes through the table
// read, then a decision step that writes back a freshly allocated entry and fills
// the output register; no new item is taken until that step ends and the output
// register is free. The table has no reset value: load every entry up to
// block_count before translating sectors. Configuration is to be written through
// the plain write port only while the block is idle, which it does not enforce.
module sparse_disk_sector_translate_unit #(
    parameter int TABLE_DEPTH = sdst_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [sdst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sdst_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    sdst_in_if.sink                                i_in,
    sdst_out_if.source                             o_out
);
    import sdst_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [WORD_W-1:0] DEPTH_L = WORD_W'(TABLE_DEPTH);

    typedef enum logic {S_IDLE, S_LOOKUP} t_state;

    // Configuration registers.
    logic                  r_dynamic;
    logic [SECTOR_W-1:0]   r_total;
    logic [SHIFT_W-1:0]    r_shift;
    logic [PAD_W-1:0]      r_bitmap;
    logic [PAD_W-1:0]      r_padding;
    logic [WORD_W-1:0]     r_end;
    logic [COUNT_W-1:0]    r_count;

    logic [WORD_W-1:0]     r_grown;
    logic [WORD_W-1:0]     n_grown;

    t_state                r_state;

    // Item held between the table read and the decision.
    logic                  r_lookup;
    logic [ACTION_W-1:0]   r_act;
    logic [SECTOR_W-1:0]   r_fixed_sector;
    logic [SECTOR_W-1:0]   r_sib;
    logic [IDX_W-1:0]      r_blk;
    logic [ENTRY_W-1:0]    r_widx;
    logic [OP_W-1:0]       r_op;
    logic                  r_zero;
    logic                  r_last;

    // Output register.
    logic                  r_out_valid;
    logic [ACTION_W-1:0]   r_out_action;
    logic [WORD_W-1:0]     r_out_file;
    logic                  r_out_created;
    logic [WORD_W-1:0]     r_out_new;
    logic [ENTRY_W-1:0]    r_out_widx;
    logic                  r_out_last;

    logic [ACTION_W-1:0]   n_out_action;
    logic [WORD_W-1:0]     n_out_file;
    logic                  n_out_created;
    logic [WORD_W-1:0]     n_out_new;

    // Table memory.
    logic [WORD_W-1:0]     r_table [TABLE_DEPTH];
    logic [WORD_W-1:0]     r_rd_data;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;

    logic                  in_xfer;
    logic                  out_xfer;
    logic [SECTOR_W-1:0]   blk_full;
    logic [WORD_W-1:0]     spb;
    logic [WORD_W-1:0]     sib_mask;
    logic [SECTOR_W-1:0]   sib;
    logic                  blk_bad;
    logic                  load_ok;
    logic                  alloc;
    logic [WORD_W-1:0]     alloc_start;

    logic                  a_lookup_alloc;
    logic                  n_lookup;
    logic [ACTION_W-1:0]   n_act;

    assign out_xfer = r_out_valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_xfer = i_in.valid && i_in.ready;

    assign spb      = WORD_W'(1) << r_shift;
    assign sib_mask = spb - WORD_W'(1);
    assign blk_full = i_in.sector >> r_shift;
    assign sib      = i_in.sector & sib_mask[SECTOR_W-1:0];
    assign blk_bad  = (WORD_W'(blk_full) >= WORD_W'(r_count)) ||
                      (WORD_W'(blk_full) >= DEPTH_L);
    assign load_ok  = (WORD_W'(i_in.entry_index) < WORD_W'(r_count)) &&
                      (WORD_W'(i_in.entry_index) < DEPTH_L);
    assign mem_raddr = IDX_W'(blk_full);

    // Decision taken at the input transfer; only a table lookup is left open.
    always_comb begin
        n_lookup = 1'b0;
        n_act    = ACT_RANGE;
        priority if (i_in.operation == OP_LOAD) begin
            n_act = load_ok ? ACT_LOADED : ACT_REJECT;
        end else if (i_in.sector >= r_total) begin
            n_act = ACT_RANGE;
        end else if (!r_dynamic) begin
            n_act = ACT_ACCESS;
        end else if (blk_bad) begin
            n_act = ACT_RANGE;
        end else begin
            n_lookup = 1'b1;
        end
    end

    assign alloc_start = r_end + r_grown;

    always_comb begin
        n_out_action  = r_act;
        n_out_file    = '0;
        n_out_created = 1'b0;
        n_out_new     = '0;
        alloc         = 1'b0;
        if (!r_lookup) begin
            if (r_act == ACT_ACCESS) begin
                n_out_file = WORD_W'(r_fixed_sector);
            end
        end else if (r_rd_data != UNALLOCATED) begin
            n_out_action = ACT_ACCESS;
            n_out_file   = r_rd_data + WORD_W'(r_bitmap) + WORD_W'(r_sib);
        end else if (r_op == OP_READ) begin
            n_out_action = ACT_ZERO;
        end else if (r_op == OP_FORMAT || r_zero) begin
            n_out_action = ACT_SKIP;
        end else begin
            alloc         = 1'b1;
            n_out_action  = ACT_ACCESS;
            n_out_file    = alloc_start + WORD_W'(r_bitmap) + WORD_W'(r_sib);
            n_out_created = 1'b1;
            n_out_new     = alloc_start;
        end
    end

    assign a_lookup_alloc = (r_state == S_LOOKUP) && alloc;
    assign n_grown = r_grown + WORD_W'(r_bitmap) + spb + WORD_W'(r_padding);

    // Loads write at the input transfer, allocations in the lookup cycle; the
    // two never coincide since only one item is in flight.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = IDX_W'(i_in.entry_index);
        mem_wdata = i_in.entry_value;
        if (a_lookup_alloc) begin
            mem_we    = 1'b1;
            mem_waddr = r_blk;
            mem_wdata = alloc_start;
        end else if (in_xfer && i_in.operation == OP_LOAD && load_ok) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_table[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dynamic <= 1'b1;
            r_total   <= '0;
            r_shift   <= BLOCK_SHIFT_RST;
            r_bitmap  <= BITMAP_RST;
            r_padding <= '0;
            r_end     <= '0;
            r_count   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DISK_DYNAMIC:    r_dynamic <= i_cfg_data[0];
                REG_TOTAL_SECTORS:   r_total   <= i_cfg_data[SECTOR_W-1:0];
                REG_BLOCK_SHIFT:     r_shift   <= i_cfg_data[SHIFT_W-1:0];
                REG_BITMAP_SECTORS:  r_bitmap  <= i_cfg_data[PAD_W-1:0];
                REG_PADDING_SECTORS: r_padding <= i_cfg_data[PAD_W-1:0];
                REG_END_SECTOR:      r_end     <= i_cfg_data[WORD_W-1:0];
                REG_BLOCK_COUNT:     r_count   <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_grown     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                    end
                    if (in_xfer) begin
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    if (alloc) begin
                        r_grown <= n_grown;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_lookup       <= n_lookup;
            r_act          <= n_act;
            r_fixed_sector <= i_in.sector;
            r_sib          <= sib;
            r_blk          <= IDX_W'(blk_full);
            r_widx         <= blk_full[ENTRY_W-1:0];
            r_op           <= i_in.operation;
            r_zero         <= i_in.data_all_zero;
            r_last         <= i_in.last_of_request;
        end
        if (r_state == S_LOOKUP) begin
            r_out_action  <= n_out_action;
            r_out_file    <= n_out_file;
            r_out_created <= n_out_created;
            r_out_new     <= n_out_new;
            r_out_widx    <= n_out_created ? r_widx : '0;
            r_out_last    <= r_last;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.action            = r_out_action;
    assign o_out.file_sector       = r_out_file;
    assign o_out.block_created     = r_out_created;
    assign o_out.new_block_sector  = r_out_new;
    assign o_out.table_write_index = r_out_widx;
    assign o_out.end_of_request    = r_out_last;

`ifndef SYNTHESIS
    a_valid_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_LOOKUP))
        else $error("result appeared without a table lookup");

    a_created_is_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_created) |-> (r_out_action == ACT_ACCESS))
        else $error("block created without a file access");

    a_alloc_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_lookup_alloc |=> (r_grown != $past(r_grown)))
        else $error("allocation did not grow the image");

    a_no_accept_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP) |-> !in_xfer)
        else $error("input transfer while a lookup is in flight");
`endif

endmodule

`default_nettype wire
